@@ src/rru_pkg.sv @@
// shared types, constants and field widths of the register rename unit
package rru_pkg;

  localparam int unsigned PhysRegs  = 64;
  localparam int unsigned ArchRegs  = 32;
  localparam int unsigned PhysW     = $clog2(PhysRegs);
  localparam int unsigned ArchW     = $clog2(ArchRegs);
  localparam int unsigned CntW      = $clog2(PhysRegs + 1);
  localparam int unsigned GroupSize = 8;
  localparam int unsigned Groups    = (PhysRegs + GroupSize - 1) / GroupSize;
  localparam int unsigned GrpW      = $clog2(GroupSize);
  localparam int unsigned GrpSelW   = $clog2(Groups);

  // fixed field widths
  localparam int unsigned ReqW      = 3;
  localparam int unsigned PhysFldW  = 7;
  localparam int unsigned TagW      = 6;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StatusW   = 2;

  localparam int unsigned InPackW   = ArchW + PhysFldW + TagW + DataW;
  localparam int unsigned InDataW   = ((InPackW + 7) / 8) * 8;
  localparam int unsigned OutPackW  = StatusW + PhysFldW + DataW + TagW + 3;
  localparam int unsigned OutDataW  = ((OutPackW + 7) / 8) * 8;

  localparam logic [PhysFldW-1:0] PhysNone = PhysFldW'(PhysRegs);

  typedef enum logic [ReqW-1:0] {
    ReqAlloc   = 3'd0,
    ReqWrite   = 3'd1,
    ReqFree    = 3'd2,
    ReqRetire  = 3'd3,
    ReqRestore = 3'd4,
    ReqLookup  = 3'd5
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoFree  = 2'd1,
    StInvalid = 2'd2,
    StFreed   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  // update commands for the alias tables
  typedef struct packed {
    logic             alloc_we;
    logic             retire_we;
    logic             restore;
    logic [ArchW-1:0] arch;
    logic [PhysW-1:0] phys;
  } map_ctrl_t;

endpackage

@@ src/rru_ram.sv @@
// generic single-write single-read synchronous ram with registered read data
module rru_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rru_free_search.sv @@
// registered two-level search for the highest-numbered free physical register
module rru_free_search
  import rru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PhysRegs-1:0] alloc_i,
  output logic [PhysW-1:0]    free_idx_o
);

  logic [Groups*GroupSize-1:0] free_pad;
  logic [Groups-1:0]           grp_any_d, grp_any_q;
  logic [GrpW-1:0]             grp_idx_d [Groups];
  logic [GrpW-1:0]             grp_idx_q [Groups];
  logic [GrpSelW-1:0]          grp_sel;

  // entries past the end of the file count as allocated
  assign free_pad = (Groups * GroupSize)'(~alloc_i);

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_any_d[g] = |free_pad[g*GroupSize +: GroupSize];
      grp_idx_d[g] = '0;
      for (int b = 0; b < GroupSize; b++) begin
        if (free_pad[g*GroupSize + b]) begin
          grp_idx_d[g] = GrpW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      for (int g = 0; g < Groups; g++) begin
        grp_idx_q[g] <= '0;
      end
    end else begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < Groups; g++) begin
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = 0; g < Groups; g++) begin
      if (grp_any_q[g]) begin
        grp_sel = GrpSelW'(g);
      end
    end
  end

  assign free_idx_o = PhysW'({grp_sel, grp_idx_q[grp_sel]});

endmodule

@@ src/rru_alias_tables.sv @@
// front-end and retirement alias tables; restore copies every retirement entry into the front-end table together
module rru_alias_tables
  import rru_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_ctrl_t        ctrl_i,
  input  logic [ArchW-1:0] rd_arch_i,
  output logic [PhysW-1:0] rd_phys_o
);

  logic [PhysW-1:0] front_q  [ArchRegs];
  logic [PhysW-1:0] retire_q [ArchRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ArchRegs; i++) begin
        front_q[i]  <= PhysW'(i);
        retire_q[i] <= PhysW'(i);
      end
    end else begin
      if (ctrl_i.restore) begin
        for (int i = 0; i < ArchRegs; i++) begin
          front_q[i] <= retire_q[i];
        end
      end else if (ctrl_i.alloc_we) begin
        front_q[ctrl_i.arch] <= ctrl_i.phys;
      end
      if (ctrl_i.retire_we) begin
        retire_q[ctrl_i.arch] <= ctrl_i.phys;
      end
    end
  end

  assign rd_phys_o = front_q[rd_arch_i];

endmodule

@@ src/register_rename_unit.sv @@
// register rename unit: physical register file state, alias tables and request sequencer
// sequence: an accepted request moves from idle to execute; the result register loads as
// execute finishes, held back only while the previous result still waits for its consumer;
// a new request is taken only in idle, so none is accepted before the last one finishes;
// values and tags live in synchronous rams read in the accept cycle, consumed in execute
// reset: allocated bits set for the first 32 entries, values and tags read as zero,
// both alias tables identity; no clearing pass, requests are taken right after reset
module register_rename_unit
  import rru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // arch_reg, phys_reg, instr_tag, write_data
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic [ReqW-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status, result_phys_reg, read_value, read_tag, read_tag_valid, read_allocated, file_full
  output logic [OutDataW-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic                accept;
  logic                exec_done;

  req_e                req_q;
  logic [ArchW-1:0]    arch_q;
  logic [PhysFldW-1:0] phys_q;
  logic [TagW-1:0]     tag_q;
  logic [DataW-1:0]    data_q;
  logic [PhysW-1:0]    map_q;

  logic [ArchW-1:0]    in_arch;
  logic [PhysW-1:0]    map_rd;

  logic [PhysRegs-1:0] alloc_q;
  logic [PhysRegs-1:0] tag_valid_q;
  logic [PhysRegs-1:0] val_ok_q;
  logic [CntW-1:0]     free_cnt_q, free_cnt_d;

  logic [PhysW-1:0]    free_idx;
  logic [DataW-1:0]    val_rd;
  logic [TagW-1:0]     tag_rd;

  logic                phys_ok;
  logic [PhysW-1:0]    phys_idx;
  logic                arch_nz;

  logic                do_alloc, do_write, do_free;
  map_ctrl_t           map_ctrl;

  status_e             status;
  logic [PhysFldW-1:0] result;
  logic [DataW-1:0]    rvalue;
  logic [TagW-1:0]     rtag;
  logic                rtagv, ralloc;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign exec_done     = (state_q == StExec) && (!out_valid_q || m_axis_tready);
  assign in_arch       = s_axis_tdata[ArchW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StExec;
      end
      StExec: begin
        if (exec_done) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(s_axis_tuser);
      arch_q <= in_arch;
      phys_q <= s_axis_tdata[ArchW +: PhysFldW];
      tag_q  <= s_axis_tdata[ArchW+PhysFldW +: TagW];
      data_q <= s_axis_tdata[ArchW+PhysFldW+TagW +: DataW];
      map_q  <= map_rd;
    end
  end

  rru_alias_tables u_tables (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (map_ctrl),
    .rd_arch_i (in_arch),
    .rd_phys_o (map_rd)
  );

  rru_free_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alloc_i    (alloc_q),
    .free_idx_o (free_idx)
  );

  rru_ram #(
    .Depth (PhysRegs),
    .Width (DataW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (phys_idx),
    .wdata_i (data_q),
    .re_i    (accept),
    .raddr_i (map_rd),
    .rdata_o (val_rd)
  );

  rru_ram #(
    .Depth (PhysRegs),
    .Width (TagW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (do_alloc),
    .waddr_i (free_idx),
    .wdata_i (tag_q),
    .re_i    (accept),
    .raddr_i (map_rd),
    .rdata_o (tag_rd)
  );

  assign phys_ok  = (phys_q < PhysNone);
  assign phys_idx = phys_q[PhysW-1:0];
  assign arch_nz  = (arch_q != '0);

  always_comb begin
    status   = StOk;
    result   = PhysNone;
    rvalue   = '0;
    rtag     = '0;
    rtagv    = 1'b0;
    ralloc   = 1'b0;
    do_alloc = 1'b0;
    do_write = 1'b0;
    do_free  = 1'b0;
    map_ctrl = '0;
    unique case (req_q)
      ReqAlloc: begin
        if (!arch_nz) begin
          result = '0;
        end else if (free_cnt_q == '0) begin
          status = StNoFree;
        end else begin
          result   = PhysFldW'(free_idx);
          do_alloc = exec_done;
        end
      end
      ReqWrite: begin
        if (!phys_ok) begin
          status = StInvalid;
        end else if (phys_q != '0) begin
          do_write = exec_done;
        end
      end
      ReqFree: begin
        if (phys_q == '0) begin
          status = StOk;
        end else if (!phys_ok) begin
          status = StInvalid;
        end else if (!alloc_q[phys_idx]) begin
          status = StFreed;
        end else begin
          do_free = exec_done;
        end
      end
      ReqRetire: begin
        if (!phys_ok) begin
          status = StInvalid;
        end else if (arch_nz) begin
          map_ctrl.retire_we = exec_done;
        end
      end
      ReqRestore: begin
        map_ctrl.restore = exec_done;
      end
      ReqLookup: begin
        if (!arch_nz) begin
          result = '0;
        end else begin
          result = PhysFldW'(map_q);
          rvalue = val_ok_q[map_q] ? val_rd : '0;
          rtagv  = tag_valid_q[map_q];
          rtag   = rtagv ? tag_rd : '0;
          ralloc = alloc_q[map_q];
        end
      end
      default: begin
        status = StOk;
      end
    endcase
    map_ctrl.alloc_we = do_alloc;
    map_ctrl.arch     = arch_q;
    map_ctrl.phys     = (req_q == ReqAlloc) ? free_idx : phys_idx;
  end

  always_comb begin
    free_cnt_d = free_cnt_q;
    if (do_alloc) free_cnt_d = free_cnt_q - CntW'(1);
    if (do_free)  free_cnt_d = free_cnt_q + CntW'(1);
  end

  // per-entry state kept in flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PhysRegs; i++) begin
        alloc_q[i] <= (i < ArchRegs);
      end
      tag_valid_q <= '0;
      val_ok_q    <= '0;
      free_cnt_q  <= CntW'(PhysRegs - ArchRegs);
    end else begin
      free_cnt_q <= free_cnt_d;
      if (do_alloc) begin
        alloc_q[free_idx]     <= 1'b1;
        tag_valid_q[free_idx] <= 1'b1;
      end
      if (do_write) begin
        val_ok_q[phys_idx]    <= 1'b1;
        tag_valid_q[phys_idx] <= 1'b0;
      end
      if (do_free) begin
        alloc_q[phys_idx]     <= 1'b0;
        tag_valid_q[phys_idx] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      out_data_q <= OutDataW'({(free_cnt_d == '0), ralloc, rtagv, rtag, rvalue, result, status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_p0_held: assert property (@(posedge clk_i) disable iff (!rst_ni) alloc_q[0])
    else $error("physical register zero lost its allocated bit");

  a_cnt_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_cnt_q == '0) == (&alloc_q))
    else $error("free count disagrees with allocated bits");

  a_search_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && free_cnt_q != '0) |-> !alloc_q[free_idx])
    else $error("free search returned an allocated entry");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StExec))
    else $error("accepted request did not enter execute");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> out_valid_q)
    else $error("finished request produced no result");

endmodule
